>>> design/gradient_wipe_opacity_macros.svh
// Assertion macros for the gradient wipe opacity block.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef GRADIENT_WIPE_OPACITY_MACROS_SVH
`define GRADIENT_WIPE_OPACITY_MACROS_SVH

// same-cycle implication
`define GWO_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gradient_wipe_opacity: same-cycle check failed");

// next-cycle implication
`define GWO_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gradient_wipe_opacity: next-cycle check failed");

`endif

>>> design/gwo_pkg.sv
// Shared types and constants for the gradient wipe opacity block.
// No dependencies; used by the interfaces, controller, datapath and top level.
`default_nettype none

package gwo_pkg;

   localparam int CMD_W       = 2;
   localparam int CH_W        = 8;
   localparam int LEVEL_W     = 10;
   localparam int PROG_W      = 13;
   localparam int SOFT_W      = 7;
   localparam int OPAC_W      = 13;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 13;
   localparam int DEN_W       = 25;   // holds 765 * 100 * 255

   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SCAN  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_EVAL  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_PROGRESS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOFTEN   = 1'd1;

   localparam logic [LEVEL_W-1:0] FULL_LEVEL = 10'd765;
   localparam logic [SOFT_W-1:0]  SOFT_MAX   = 7'd100;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MUL1,
      ST_MUL2,
      ST_SELECT,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_RESULT
   } gwo_state_type;

   typedef struct packed {
      logic load;
      logic update;
      logic mul1;
      logic mul2;
      logic select;
      logic div_start;
      logic finish;
   } gwo_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] item_op;
      logic             zero;
      logic             div_busy;
   } gwo_status_type;

endpackage

`default_nettype wire

>>> design/gwo_req_if.sv
// Request channel: valid/ready handshake carrying one pixel word.
// Depends on gwo_pkg for field widths.
`default_nettype none

interface gwo_req_if;
   logic                        valid;
   logic                        ready;
   logic [gwo_pkg::CMD_W-1:0]   req_command;
   logic [gwo_pkg::CH_W-1:0]    req_red;
   logic [gwo_pkg::CH_W-1:0]    req_green;
   logic [gwo_pkg::CH_W-1:0]    req_blue;
   logic [gwo_pkg::CH_W-1:0]    req_alpha;
   logic                        req_inside_req;

   modport source (
      output valid, req_command, req_red, req_green, req_blue, req_alpha, req_inside_req,
      input  ready
   );
   modport sink (
      input  valid, req_command, req_red, req_green, req_blue, req_alpha, req_inside_req,
      output ready
   );
endinterface

`default_nettype wire

>>> design/gwo_rsp_if.sv
// Response channel: valid/ready handshake carrying one opacity word.
// Depends on gwo_pkg for the field width.
`default_nettype none

interface gwo_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [gwo_pkg::OPAC_W-1:0] rsp_opacity;

   modport source (output valid, rsp_opacity, input ready);
   modport sink   (input valid, rsp_opacity, output ready);
endinterface

`default_nettype wire

>>> design/gwo_div.sv
// Restoring divider, one quotient bit per cycle.
// Standalone; instantiated by gwo_dpath. Quotient must fit in QUO_W bits.
`default_nettype none

module gwo_div #(
   parameter int NUM_W = 37,
   parameter int QUO_W = 13,
   parameter int DEN_W = 25
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] numer,
   input  wire logic [DEN_W-1:0] denom,
   output logic                  busy,
   output logic [QUO_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(QUO_W + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [QUO_W-1:0] low_ff, low_in;
   logic [DEN_W:0]   trial;
   logic             ge;

   assign busy     = (cnt_ff != '0);
   assign quotient = low_ff;

   // low_ff holds the dividend bits still to be shifted in, then the quotient
   always_comb begin
      trial  = {rem_ff, low_ff[QUO_W-1]};
      ge     = (trial >= {1'b0, den_ff});
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      low_in = low_ff;
      den_in = den_ff;
      if (start) begin
         cnt_in = CNT_W'(QUO_W);
         rem_in = DEN_W'(numer[NUM_W-1:QUO_W]);
         low_in = numer[QUO_W-1:0];
         den_in = denom;
      end else if (busy) begin
         cnt_in = cnt_ff - 1'b1;
         rem_in = ge ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
         low_in = {low_ff[QUO_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      den_ff <= den_in;
   end

endmodule

`default_nettype wire

>>> design/gwo_ctrl.sv
// Controller FSM: sequences the datapath and owns both handshakes.
// Depends on gwo_pkg for state, command and status types.
`default_nettype none

module gwo_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output gwo_pkg::gwo_cmd_type         cmd,
   input  wire gwo_pkg::gwo_status_type status
);

   gwo_pkg::gwo_state_type state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gwo_pkg::ST_IDLE: begin
            if (req_valid) state_in = gwo_pkg::ST_DECODE;
         end
         gwo_pkg::ST_DECODE: begin
            state_in = (status.item_op == gwo_pkg::CMD_EVAL) ? gwo_pkg::ST_MUL1
                                                              : gwo_pkg::ST_IDLE;
         end
         gwo_pkg::ST_MUL1:   state_in = gwo_pkg::ST_MUL2;
         gwo_pkg::ST_MUL2:   state_in = gwo_pkg::ST_SELECT;
         gwo_pkg::ST_SELECT: state_in = gwo_pkg::ST_DIV_LOAD;
         gwo_pkg::ST_DIV_LOAD: begin
            state_in = status.zero ? gwo_pkg::ST_RESULT : gwo_pkg::ST_DIV_RUN;
         end
         gwo_pkg::ST_DIV_RUN: begin
            if (!status.div_busy) state_in = gwo_pkg::ST_RESULT;
         end
         gwo_pkg::ST_RESULT: begin
            if (out_free) state_in = gwo_pkg::ST_IDLE;
         end
         default: state_in = gwo_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         gwo_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         gwo_pkg::ST_DECODE:   cmd.update    = (status.item_op != gwo_pkg::CMD_EVAL);
         gwo_pkg::ST_MUL1:     cmd.mul1      = 1'b1;
         gwo_pkg::ST_MUL2:     cmd.mul2      = 1'b1;
         gwo_pkg::ST_SELECT:   cmd.select    = 1'b1;
         gwo_pkg::ST_DIV_LOAD: cmd.div_start = !status.zero;
         gwo_pkg::ST_DIV_RUN:  cmd           = '0;
         gwo_pkg::ST_RESULT:   cmd.finish    = out_free;
         default:              cmd           = '0;
      endcase
   end

   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gwo_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

>>> design/gwo_dpath.sv
// Datapath: lightness extremes, fixed-point compare chain and ramp divider.
// Depends on gwo_pkg and gwo_div; driven by gwo_ctrl commands.
`default_nettype none

module gwo_dpath #(
   parameter int FRAC_BITS = 12
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire gwo_pkg::gwo_cmd_type        cmd,
   output gwo_pkg::gwo_status_type          status,
   input  wire logic [gwo_pkg::CMD_W-1:0]   req_command,
   input  wire logic [gwo_pkg::CH_W-1:0]    req_red,
   input  wire logic [gwo_pkg::CH_W-1:0]    req_green,
   input  wire logic [gwo_pkg::CH_W-1:0]    req_blue,
   input  wire logic [gwo_pkg::CH_W-1:0]    req_alpha,
   input  wire logic                        req_inside_req,
   input  wire logic [gwo_pkg::PROG_W-1:0]  progress,
   input  wire logic [gwo_pkg::SOFT_W-1:0]  soften,
   output logic [gwo_pkg::OPAC_W-1:0]       opacity
);

   localparam int LVW  = gwo_pkg::LEVEL_W;
   localparam int OW   = gwo_pkg::OPAC_W;
   localparam int DW   = gwo_pkg::DEN_W;
   localparam int PW   = FRAC_BITS + 1;                 // p in [0, ONE]
   localparam int CW   = (PW > gwo_pkg::PROG_W) ? PW + 1 : gwo_pkg::PROG_W + 1;
   localparam int HW   = PW + 7;                        // 100*p, s*(ONE-p)
   localparam int TW   = HW + 1;                        // signed t
   localparam int NDW  = LVW + 1;                       // signed L - darkest
   localparam int SDW  = gwo_pkg::SOFT_W + LVW;         // s*d
   localparam int LW   = FRAC_BITS + 18;                // signed lhs
   localparam int RW   = TW + NDW;                      // signed rhs
   localparam int SODW = FRAC_BITS + SDW;               // s*ONE*d
   localparam int CMPW = FRAC_BITS + 22;
   localparam int QW   = FRAC_BITS + 1;
   localparam int NW   = SODW + gwo_pkg::CH_W;

   localparam logic [CW-1:0] ONE_CW = CW'(1) << FRAC_BITS;
   localparam logic [PW-1:0] ONE_PW = PW'(1) << FRAC_BITS;

   // item
   logic [gwo_pkg::CMD_W-1:0] op_ff;
   logic [LVW-1:0]            level_ff;
   logic [gwo_pkg::CH_W-1:0]  alpha_ff;
   logic                      inside_ff;
   // extremes
   logic [LVW-1:0]            dark_ff, dark_in;
   logic [LVW-1:0]            bright_ff, bright_in;
   // first product step
   logic [CW-1:0]             prog_wide, p_sat;
   logic [PW-1:0]             p_val, one_minus;
   logic [gwo_pkg::SOFT_W-1:0] soft_sat;
   logic [HW-1:0]             hp, sq;
   logic signed [TW-1:0]      t_ff, t_in;
   logic signed [NDW-1:0]     n_ff, n_in;
   logic [LVW-1:0]            d_ff, d_in;
   logic [SDW-1:0]            sd_ff, sd_in;
   // second product step
   logic signed [LW-1:0]      lhs_ff, lhs_in;
   logic signed [RW-1:0]      rhs_ff, rhs_in;
   logic [SODW-1:0]           sod_ff, sod_in;
   logic [DW-1:0]             den_ff, den_in;
   // select step
   logic signed [CMPW-1:0]    lhs_c, rhs_c, sod_c, diff;
   logic                      full_ff, full_in;
   logic [SODW-1:0]           r_ff, r_in;
   logic                      zero_ff, zero_in;
   // divide
   logic [NW-1:0]             div_num;
   logic [DW-1:0]             div_den;
   logic                      div_busy;
   logic [QW-1:0]             quot;
   logic [OW-1:0]             opacity_ff, opacity_in;

   assign status.item_op  = op_ff;
   assign status.zero     = zero_ff;
   assign status.div_busy = div_busy;
   assign opacity         = opacity_ff;

   // extremes update
   always_comb begin
      dark_in   = dark_ff;
      bright_in = bright_ff;
      if (op_ff == gwo_pkg::CMD_CLEAR) begin
         dark_in   = gwo_pkg::FULL_LEVEL;
         bright_in = '0;
      end else if (op_ff == gwo_pkg::CMD_SCAN && alpha_ff != '0) begin
         if (level_ff < dark_ff)   dark_in   = level_ff;
         if (level_ff > bright_ff) bright_in = level_ff;
      end
   end

   // t = 100*p - s*(ONE-p), the threshold scaled by 100*ONE
   always_comb begin
      prog_wide = CW'(progress);
      p_sat     = (prog_wide > ONE_CW) ? ONE_CW : prog_wide;
      p_val     = PW'(p_sat);
      soft_sat  = (soften > gwo_pkg::SOFT_MAX) ? gwo_pkg::SOFT_MAX : soften;
      one_minus = ONE_PW - p_val;
      hp        = HW'(p_val) * HW'(100);
      sq        = HW'(soft_sat) * HW'(one_minus);
      t_in      = $signed({1'b0, hp}) - $signed({1'b0, sq});
      n_in      = $signed({1'b0, level_ff}) - $signed({1'b0, dark_ff});
      d_in      = bright_ff - dark_ff;
      sd_in     = SDW'(soft_sat) * SDW'(d_in);
   end

   always_comb begin
      lhs_in = (LW'(n_ff) * LW'(100)) <<< FRAC_BITS;
      rhs_in = RW'($signed({1'b0, d_ff})) * RW'(t_ff);
      sod_in = SODW'(sd_ff) << FRAC_BITS;
      den_in = DW'(sd_ff) * DW'(255);
   end

   // with s = 0, diff equals rhs - lhs, negative whenever the full case fails
   always_comb begin
      lhs_c   = CMPW'(lhs_ff);
      rhs_c   = CMPW'(rhs_ff);
      sod_c   = CMPW'($signed({1'b0, sod_ff}));
      diff    = rhs_c - lhs_c + sod_c;
      full_in = (lhs_c <= rhs_c);
      r_in    = SODW'(diff);
   end

   always_comb begin
      if (cmd.mul1) begin
         zero_in = !inside_ff || (bright_ff <= dark_ff);
      end else if (cmd.select) begin
         zero_in = zero_ff || (!full_in && diff[CMPW-1]);
      end else begin
         zero_in = zero_ff;
      end
   end

   // full case: alpha*ONE/255; ramp: r*alpha/(s*d*255)
   always_comb begin
      div_num    = full_ff ? (NW'(alpha_ff) << FRAC_BITS) : (NW'(r_ff) * NW'(alpha_ff));
      div_den    = full_ff ? DW'(255) : den_ff;
      opacity_in = zero_ff ? '0 : OW'(quot);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dark_ff   <= gwo_pkg::FULL_LEVEL;
         bright_ff <= '0;
      end else if (cmd.update) begin
         dark_ff   <= dark_in;
         bright_ff <= bright_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_command;
         level_ff  <= LVW'(req_red) + LVW'(req_green) + LVW'(req_blue);
         alpha_ff  <= req_alpha;
         inside_ff <= req_inside_req;
      end
      if (cmd.mul1) begin
         t_ff  <= t_in;
         n_ff  <= n_in;
         d_ff  <= d_in;
         sd_ff <= sd_in;
      end
      if (cmd.mul2) begin
         lhs_ff <= lhs_in;
         rhs_ff <= rhs_in;
         sod_ff <= sod_in;
         den_ff <= den_in;
      end
      if (cmd.select) begin
         full_ff <= full_in;
         r_ff    <= r_in;
      end
      zero_ff <= zero_in;
      if (cmd.finish) begin
         opacity_ff <= opacity_in;
      end
   end

   gwo_div #(
      .NUM_W (NW),
      .QUO_W (QW),
      .DEN_W (DW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .numer    (div_num),
      .denom    (div_den),
      .busy     (div_busy),
      .quotient (quot)
   );

endmodule

`default_nettype wire

>>> design/gradient_wipe_opacity.sv
// Gradient wipe opacity generator, top level.
// Channels: req (sink) takes one word per pixel with a command: clear
// resets the darkest/lightest extremes, scan folds R+G+B of pixels with
// nonzero alpha into them, evaluate returns one Q(OPACITY_FRAC_BITS)
// opacity word on rsp. Clear, scan and unused commands give no word.
// csr_wr_en/csr_index/csr_wr_data write progress (index 0) and soften
// percent (index 1). The user must write only while the block is idle;
// the block itself does not enforce it. Clear and scan pass through
// decode and back to idle. An evaluate that lands inside the ramp or
// fully shown runs the restoring divider, one quotient bit per cycle
// over OPACITY_FRAC_BITS+1 bits, after the mul1, mul2 and select steps;
// zero-opacity cases skip it. The next word is taken once rsp has it.
// Reset: extremes go to 765/0, progress and soften to 0, no word pending.
// A stalled rsp holds its word; one more item can be taken and worked
// on, and it waits in its final step until the output register frees.
`default_nettype none
`include "gradient_wipe_opacity_macros.svh"

module gradient_wipe_opacity #(
   parameter int OPACITY_FRAC_BITS = 12
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   gwo_req_if.sink                               req,
   gwo_rsp_if.source                             rsp,
   input  wire logic                             csr_wr_en,
   input  wire logic [gwo_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [gwo_pkg::CSR_DATA_W-1:0]   csr_wr_data
);

   logic [gwo_pkg::PROG_W-1:0] progress_ff;
   logic [gwo_pkg::SOFT_W-1:0] soften_ff;
   gwo_pkg::gwo_cmd_type       cmd;
   gwo_pkg::gwo_status_type    status;
   logic                       req_ready;
   logic                       rsp_valid;
   logic [gwo_pkg::OPAC_W-1:0] opacity;
   logic                       short_accept;
   logic                       opacity_ok;

   assign req.ready       = req_ready;
   assign rsp.valid       = rsp_valid;
   assign rsp.rsp_opacity = opacity;

   always_ff @(posedge clock) begin
      if (reset) begin
         progress_ff <= '0;
         soften_ff   <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            gwo_pkg::CSR_PROGRESS: progress_ff <= csr_wr_data[gwo_pkg::PROG_W-1:0];
            gwo_pkg::CSR_SOFTEN:   soften_ff   <= csr_wr_data[gwo_pkg::SOFT_W-1:0];
            default: ;
         endcase
      end
   end

   gwo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd),
      .status    (status)
   );

   gwo_dpath #(
      .FRAC_BITS (OPACITY_FRAC_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_command    (req.req_command),
      .req_red        (req.req_red),
      .req_green      (req.req_green),
      .req_blue       (req.req_blue),
      .req_alpha      (req.req_alpha),
      .req_inside_req (req.req_inside_req),
      .progress       (progress_ff),
      .soften         (soften_ff),
      .opacity        (opacity)
   );

   assign short_accept = req.valid && req.ready && (req.req_command != gwo_pkg::CMD_EVAL);
   assign opacity_ok   = (OPACITY_FRAC_BITS > gwo_pkg::OPAC_W - 1) ||
                         (int'(rsp.rsp_opacity) <= (1 << OPACITY_FRAC_BITS));

   // an accepted word always leaves the input not ready in the next cycle
   `GWO_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready)
   // clear/scan words free the input again once the controller is back in idle
   `GWO_ASSERT_NOW(a_short_cmd_turnaround, short_accept, ##2 req.ready)
   // the divider never yields more than full opacity
   `GWO_ASSERT_NOW(a_opacity_range, rsp.valid, opacity_ok)

endmodule

`default_nettype wire
